// ===== sv/ablm_pkg.sv =====
// Shared types and constants for the audio block level meter.
`default_nettype none
package ablm_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int LEVEL_W       = 16;
    localparam int TOTAL_W       = 64;
    localparam int WEIGHT_W      = 17;
    localparam int FRAC_W        = 16;
    localparam int SMOOTH_W      = 32;
    localparam int QUOT_W        = 31;
    localparam int ROOT_W        = 32;
    localparam int SQRT_STEPS    = 16;
    localparam int MAX_BLOCK_DEF = 4096;
    localparam int APB_DW        = 32;
    localparam int APB_AW        = 2;

    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = 17'h10000;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 17'd6554;
    localparam logic [ROOT_W-1:0]   ROOT_START   = 32'h4000_0000;
    localparam logic [APB_AW-1:0]   ADDR_WEIGHT  = 2'd0;

    typedef struct packed {
        logic acc_en;
        logic div_step;
        logic sqrt_init;
        logic sqrt_step;
        logic ema_mul;
        logic ema_upd;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic close;
    } t_sts;

endpackage
`default_nettype wire

// ===== sv/ablm_ctrl.sv =====
// Sequencer for sample accumulation, divide, square root, average and output.
`default_nettype none
module ablm_ctrl #(
    parameter int MAX_BLOCK = ablm_pkg::MAX_BLOCK_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_out_stall,
    input  wire ablm_pkg::t_sts i_sts,
    output ablm_pkg::t_cmd     o_cmd,
    output logic               o_in_stall,
    output logic               o_out_valid
);
    import ablm_pkg::*;

    localparam int CW   = $clog2(MAX_BLOCK + 1);
    localparam int SW   = 2 * SAMPLE_W - 2 + CW;
    localparam int CNTW = $clog2(SW);

    typedef enum logic [2:0] {
        S_ACC,
        S_DIV,
        S_SQI,
        S_SQRT,
        S_EMA1,
        S_EMA2,
        S_OUT
    } t_state;

    t_state            r_state, n_state;
    logic [CNTW-1:0]   r_cnt, n_cnt;
    logic              r_stall, n_stall;
    logic              r_out_valid, n_out_valid;
    logic              load;

    always_comb begin
        o_cmd     = '0;
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_stall   = r_stall;
        load      = 1'b0;
        case (r_state)
            S_ACC: begin
                o_cmd.acc_en = i_in_valid;
                if (i_in_valid && i_sts.close) begin
                    n_state = S_DIV;
                    n_cnt   = '0;
                    n_stall = 1'b1;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNTW'(SW - 1)) begin
                    n_state = S_SQI;
                end
            end
            S_SQI: begin
                o_cmd.sqrt_init = 1'b1;
                n_cnt   = '0;
                n_state = S_SQRT;
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNTW'(SQRT_STEPS - 1)) begin
                    n_state = S_EMA1;
                end
            end
            S_EMA1: begin
                o_cmd.ema_mul = 1'b1;
                n_state = S_EMA2;
            end
            S_EMA2: begin
                o_cmd.ema_upd = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    load           = 1'b1;
                    o_cmd.load_out = 1'b1;
                    n_state        = S_ACC;
                    n_stall        = 1'b0;
                end
            end
            default: begin
                n_state = S_ACC;
                n_stall = 1'b0;
            end
        endcase
        if (load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_ACC;
            r_cnt       <= '0;
            r_stall     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_stall     <= n_stall;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = r_stall;
    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

// ===== sv/ablm_dp.sv =====
// Datapath: block accumulators, shift-subtract divider, digit square root, moving average.
`default_nettype none
module ablm_dp #(
    parameter int MAX_BLOCK = ablm_pkg::MAX_BLOCK_DEF
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire ablm_pkg::t_cmd                         i_cmd,
    output ablm_pkg::t_sts                              o_sts,
    input  wire logic signed [ablm_pkg::SAMPLE_W-1:0]  i_sample,
    input  wire logic                                   i_last,
    input  wire logic [ablm_pkg::WEIGHT_W-1:0]         i_weight,
    output logic [ablm_pkg::LEVEL_W-1:0]               o_rms_level,
    output logic [ablm_pkg::LEVEL_W-1:0]               o_peak_level,
    output logic [ablm_pkg::LEVEL_W-1:0]               o_ema_level,
    output logic [ablm_pkg::TOTAL_W-1:0]               o_total_samples
);
    import ablm_pkg::*;

    localparam int CW  = $clog2(MAX_BLOCK + 1);
    localparam int SW  = 2 * SAMPLE_W - 2 + CW;
    localparam int SQW = 2 * SAMPLE_W;
    localparam int P1W = WEIGHT_W + LEVEL_W;
    localparam int P2W = WEIGHT_W + SMOOTH_W;

    logic [SW-1:0]       r_sum, n_sum;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic [LEVEL_W-1:0]  r_peak, n_peak;
    logic [TOTAL_W-1:0]  r_total, n_total;
    logic [SMOOTH_W-1:0] r_smooth, n_smooth;

    logic [SW-1:0]       r_dvd;
    logic [CW-1:0]       r_dvs;
    logic [CW-1:0]       r_rem;
    logic [LEVEL_W-1:0]  r_peak_hold;
    logic [TOTAL_W-1:0]  r_total_hold;
    logic [QUOT_W-1:0]   r_v;
    logic [ROOT_W-1:0]   r_root;
    logic [ROOT_W-1:0]   r_bit;
    logic [P1W-1:0]      r_p1;
    logic [P2W-1:0]      r_p2;
    logic [LEVEL_W-1:0]  r_o_rms, r_o_peak, r_o_ema;
    logic [TOTAL_W-1:0]  r_o_total;

    logic [SAMPLE_W-1:0] raw;
    logic [LEVEL_W-1:0]  mag;
    logic [SQW-1:0]      sq;
    logic                close;
    logic [CW:0]         rem_sh, rem_diff;
    logic                div_ge;
    logic [ROOT_W-1:0]   sq_t, sq_diff;
    logic                sq_ge;
    logic [WEIGHT_W-1:0] wc;

    assign raw     = i_sample;
    assign mag     = raw[SAMPLE_W-1] ? LEVEL_W'(~raw + 1'b1) : LEVEL_W'(raw);
    assign sq      = SQW'(mag) * SQW'(mag);
    assign n_sum   = r_sum + SW'(sq);
    assign n_cnt   = r_cnt + 1'b1;
    assign n_peak  = (mag > r_peak) ? mag : r_peak;
    assign n_total = r_total + 1'b1;
    assign close   = i_last || (n_cnt == CW'(MAX_BLOCK));
    assign o_sts.close = close;

    assign rem_sh   = {r_rem, r_dvd[SW-1]};
    assign div_ge   = rem_sh >= {1'b0, r_dvs};
    assign rem_diff = rem_sh - {1'b0, r_dvs};

    assign sq_t    = r_root + r_bit;
    assign sq_ge   = ROOT_W'(r_v) >= sq_t;
    assign sq_diff = ROOT_W'(r_v) - sq_t;

    assign wc       = WEIGHT_ONE - i_weight;
    assign n_smooth = SMOOTH_W'(r_p1 + P1W'(r_p2[P2W-1:FRAC_W]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum    <= '0;
            r_cnt    <= '0;
            r_peak   <= '0;
            r_total  <= '0;
            r_smooth <= '0;
        end else begin
            if (i_cmd.acc_en) begin
                r_total <= n_total;
                if (close) begin
                    r_sum  <= '0;
                    r_cnt  <= '0;
                    r_peak <= '0;
                end else begin
                    r_sum  <= n_sum;
                    r_cnt  <= n_cnt;
                    r_peak <= n_peak;
                end
            end
            if (i_cmd.ema_upd) begin
                r_smooth <= n_smooth;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_en && close) begin
            r_dvd        <= n_sum;
            r_dvs        <= n_cnt;
            r_rem        <= '0;
            r_peak_hold  <= n_peak;
            r_total_hold <= n_total;
        end
        if (i_cmd.div_step) begin
            r_dvd <= {r_dvd[SW-2:0], div_ge};
            r_rem <= div_ge ? rem_diff[CW-1:0] : rem_sh[CW-1:0];
        end
        if (i_cmd.sqrt_init) begin
            r_v    <= r_dvd[QUOT_W-1:0];
            r_root <= '0;
            r_bit  <= ROOT_START;
        end
        if (i_cmd.sqrt_step) begin
            if (sq_ge) begin
                r_v    <= sq_diff[QUOT_W-1:0];
                r_root <= (r_root >> 1) + r_bit;
            end else begin
                r_root <= r_root >> 1;
            end
            r_bit <= r_bit >> 2;
        end
        if (i_cmd.ema_mul) begin
            r_p1 <= P1W'(i_weight) * P1W'(r_root[LEVEL_W-1:0]);
            r_p2 <= P2W'(wc) * P2W'(r_smooth);
        end
        if (i_cmd.load_out) begin
            r_o_rms   <= r_root[LEVEL_W-1:0];
            r_o_peak  <= r_peak_hold;
            r_o_ema   <= r_smooth[SMOOTH_W-1:FRAC_W];
            r_o_total <= r_total_hold;
        end
    end

    assign o_rms_level     = r_o_rms;
    assign o_peak_level    = r_o_peak;
    assign o_ema_level     = r_o_ema;
    assign o_total_samples = r_o_total;

endmodule
`default_nettype wire

// ===== sv/audio_block_level_meter_top.sv =====
// Audio block level meter: block RMS, peak, smoothed RMS and sample total.
// Samples are taken one per cycle while a block is open.
// Closing a block runs the shift-subtract divider steps, a square root init and its steps,
// then the average multiply, the average update and the output load.
// Input is stalled during that back end; results leave through an output register.
// Synchronous active-low reset clears the accumulators, average and total and sets the weight to 6554.
`default_nettype none
module audio_block_level_meter_top #(
    parameter int MAX_BLOCK = ablm_pkg::MAX_BLOCK_DEF
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_in_valid,
    output logic                                        o_in_stall,
    input  wire logic signed [ablm_pkg::SAMPLE_W-1:0]  i_sample,
    input  wire logic                                   i_last,
    output logic                                        o_out_valid,
    input  wire logic                                   i_out_stall,
    output logic [ablm_pkg::LEVEL_W-1:0]               o_rms_level,
    output logic [ablm_pkg::LEVEL_W-1:0]               o_peak_level,
    output logic [ablm_pkg::LEVEL_W-1:0]               o_ema_level,
    output logic [ablm_pkg::TOTAL_W-1:0]               o_total_samples,
    input  wire logic                                   psel,
    input  wire logic                                   penable,
    input  wire logic                                   pwrite,
    input  wire logic [ablm_pkg::APB_AW-1:0]           paddr,
    input  wire logic [ablm_pkg::APB_DW-1:0]           pwdata,
    output logic [ablm_pkg::APB_DW-1:0]                prdata,
    output logic                                        pready
);
    import ablm_pkg::*;

    t_cmd                cmd;
    t_sts                sts;
    logic [WEIGHT_W-1:0] r_weight, n_weight;
    logic [WEIGHT_W-1:0] wr_val;

    assign pready = 1'b1;
    assign wr_val = pwdata[WEIGHT_W-1:0];

    always_comb begin
        n_weight = r_weight;
        if (psel && penable && pwrite && paddr == ADDR_WEIGHT) begin
            n_weight = (wr_val > WEIGHT_ONE) ? WEIGHT_ONE : wr_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight <= WEIGHT_RESET;
        end else begin
            r_weight <= n_weight;
        end
    end

    assign prdata = (paddr == ADDR_WEIGHT) ? APB_DW'(r_weight) : '0;

    ablm_ctrl #(
        .MAX_BLOCK(MAX_BLOCK)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    ablm_dp #(
        .MAX_BLOCK(MAX_BLOCK)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_sample        (i_sample),
        .i_last          (i_last),
        .i_weight        (r_weight),
        .o_rms_level     (o_rms_level),
        .o_peak_level    (o_peak_level),
        .o_ema_level     (o_ema_level),
        .o_total_samples (o_total_samples)
    );

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench for the audio block level meter: block RMS, peak, average, total, weight readback.
module tb;
    import ablm_pkg::*;

    localparam int PERIOD       = 8;
    localparam int RESET_CYCLES = 9;
    localparam int DRAIN_CYCLES = 120;
    localparam int HOLD_CYCLES  = 600;
    localparam int IDLE_PCT     = 24;
    localparam int REPORT_MAX   = 10;
    localparam longint TIMEOUT  = 64'd1_500_000 * PERIOD;

    typedef struct packed {
        logic [LEVEL_W-1:0] rms;
        logic [LEVEL_W-1:0] peak;
        logic [LEVEL_W-1:0] ema;
        logic [TOTAL_W-1:0] total;
    } t_level;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_stall;
    logic signed [SAMPLE_W-1:0] i_sample = '0;
    logic                       i_last = 1'b0;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    logic [LEVEL_W-1:0]         o_rms_level;
    logic [LEVEL_W-1:0]         o_peak_level;
    logic [LEVEL_W-1:0]         o_ema_level;
    logic [TOTAL_W-1:0]         o_total_samples;
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [APB_AW-1:0]          paddr = '0;
    logic [APB_DW-1:0]          pwdata = '0;
    logic [APB_DW-1:0]          prdata;
    logic                       pready;

    // predicted meter state
    logic [WEIGHT_W-1:0] weight_r   = WEIGHT_RESET;
    logic [63:0]         sq_acc     = '0;
    int                  peak_acc   = 0;
    int                  count_acc  = 0;
    logic [SMOOTH_W-1:0] smooth_q16 = '0;
    logic [TOTAL_W-1:0]  seen_total = '0;

    t_level levels_due[$];
    int     errors = 0;
    bit     calm_in = 1'b0;
    bit     calm_out = 1'b0;
    int     hold_serial = 0;
    int     hold_seen = 0;
    int     hold_left = 0;

    audio_block_level_meter_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_sample        (i_sample),
        .i_last          (i_last),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_rms_level     (o_rms_level),
        .o_peak_level    (o_peak_level),
        .o_ema_level     (o_ema_level),
        .o_total_samples (o_total_samples),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #(PERIOD / 2) i_clk = ~i_clk;

    task automatic note_mismatch(input string what, input logic [63:0] exp_v,
                                 input logic [63:0] act_v);
        errors++;
        if (errors <= REPORT_MAX) begin
            $display("%0t mismatch %s: expected %0d, got %0d", $realtime, what, exp_v, act_v);
        end
    endtask

    task automatic account_sample(input logic signed [SAMPLE_W-1:0] s, input logic l);
        int          mag;
        logic [63:0] quo;
        logic [63:0] root;
        logic [63:0] trial;
        logic [63:0] mix;
        t_level      lv;
        mag = (s < 0) ? -int'(s) : int'(s);
        sq_acc += 64'(mag) * 64'(mag);
        if (mag > peak_acc) begin
            peak_acc = mag;
        end
        count_acc++;
        seen_total++;
        if (l || count_acc == MAX_BLOCK_DEF) begin
            quo  = sq_acc / 64'(count_acc);
            root = '0;
            for (int b = 16; b >= 0; b--) begin
                trial = root | (64'd1 << b);
                if (trial * trial <= quo) begin
                    root = trial;
                end
            end
            mix = 64'(weight_r) * (root << FRAC_W)
                + 64'(WEIGHT_ONE - weight_r) * 64'(smooth_q16);
            smooth_q16 = mix[FRAC_W +: SMOOTH_W];
            lv.rms   = root[LEVEL_W-1:0];
            lv.peak  = LEVEL_W'(peak_acc);
            lv.ema   = smooth_q16[SMOOTH_W-1 -: LEVEL_W];
            lv.total = seen_total;
            levels_due.push_back(lv);
            sq_acc    = '0;
            peak_acc  = 0;
            count_acc = 0;
        end
    endtask

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic l);
        while (!calm_in && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample   <= s;
        i_last     <= l;
        do @(posedge i_clk); while (o_in_stall);
        account_sample(s, l);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(9))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return SAMPLE_W'($urandom_range(8) - 4);
            default: return SAMPLE_W'($urandom());
        endcase
    endfunction

    task automatic send_block(input int len);
        for (int k = 1; k <= len; k++) begin
            send_sample(pick_sample(), k == len);
        end
    endtask

    task automatic wait_drained;
        i_in_valid <= 1'b0;
        while (levels_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
        logic [WEIGHT_W-1:0] v;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (addr == ADDR_WEIGHT) begin
            v = data[WEIGHT_W-1:0];
            weight_r = (v > WEIGHT_ONE) ? WEIGHT_ONE : v;
        end
        @(posedge i_clk);
    endtask

    task automatic check_weight_readback;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_WEIGHT;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== APB_DW'(weight_r)) begin
            note_mismatch("weight readback", 64'(weight_r), 64'(prdata));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic test_extremes;
        send_sample(16'sd0, 1'b1);
        send_sample(16'sh8000, 1'b1);
        send_sample(16'sh7FFF, 1'b1);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sd1, 1'b0);
        send_sample(-16'sd1, 1'b0);
        send_sample(16'sd0, 1'b1);
        send_sample(-16'sd1, 1'b0);
        send_sample(16'sd1, 1'b1);
        wait_drained();
    endtask

    task automatic test_weight_settings;
        check_weight_readback();
        write_reg(ADDR_WEIGHT, '0);
        check_weight_readback();
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh4000, 1'b1);
        wait_drained();
        write_reg(ADDR_WEIGHT, APB_DW'(WEIGHT_ONE));
        check_weight_readback();
        send_sample(16'sh7FFF, 1'b0);
        send_sample(-16'sd300, 1'b1);
        wait_drained();
        // saturate writes above one
        write_reg(ADDR_WEIGHT, 32'h0001_FFFF);
        check_weight_readback();
        write_reg(ADDR_WEIGHT, 32'h0001_0001);
        check_weight_readback();
        send_sample(16'sd1000, 1'b1);
        wait_drained();
        write_reg(ADDR_WEIGHT, 32'hFFFE_8000);
        check_weight_readback();
        // unused addresses leave the weight alone
        for (int a = 0; a < 2 ** APB_AW; a++) begin
            if (APB_AW'(a) != ADDR_WEIGHT) begin
                write_reg(APB_AW'(a), 32'h0000_1234);
            end
        end
        check_weight_readback();
        send_sample(-16'sd20000, 1'b0);
        send_sample(16'sd12345, 1'b1);
        wait_drained();
        write_reg(ADDR_WEIGHT, APB_DW'(WEIGHT_RESET));
        check_weight_readback();
    endtask

    task automatic test_full_block;
        // block closes on its own at full length
        for (int k = 0; k < MAX_BLOCK_DEF; k++) begin
            send_sample(16'sh8000, 1'b0);
        end
        send_block(3);
        wait_drained();
    endtask

    task automatic test_backpressure;
        hold_serial <= hold_serial + 1;
        for (int k = 0; k < 30; k++) begin
            send_block($urandom_range(1, 3));
        end
        wait_drained();
    endtask

    task automatic test_random;
        int sent;
        int len;
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: write_reg(ADDR_WEIGHT, APB_DW'($urandom_range(65536)));
                1: write_reg(ADDR_WEIGHT, '0);
                2: write_reg(ADDR_WEIGHT, APB_DW'(WEIGHT_ONE));
                3: write_reg(ADDR_WEIGHT, $urandom());
                default: write_reg(ADDR_WEIGHT, APB_DW'(WEIGHT_RESET));
            endcase
            check_weight_readback();
            calm_in  = (phase == 2);
            calm_out <= (phase == 2);
            sent = 0;
            while (sent < 190) begin
                case ($urandom_range(19))
                    0:       len = $urandom_range(65, 300);
                    1, 2, 3: len = $urandom_range(13, 64);
                    default: len = $urandom_range(1, 12);
                endcase
                send_block(len);
                sent += len;
            end
            wait_drained();
        end
        calm_in  = 1'b0;
        calm_out <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            hold_seen   <= 0;
            hold_left   <= 0;
        end else if (hold_seen != hold_serial) begin
            hold_seen   <= hold_serial;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !calm_out && ($urandom_range(99) < IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin : check_levels
        t_level lv;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (levels_due.size() == 0) begin
                note_mismatch("unexpected result total", '0, o_total_samples);
            end else begin
                lv = levels_due.pop_front();
                if (o_rms_level !== lv.rms) begin
                    note_mismatch("rms_level", 64'(lv.rms), 64'(o_rms_level));
                end
                if (o_peak_level !== lv.peak) begin
                    note_mismatch("peak_level", 64'(lv.peak), 64'(o_peak_level));
                end
                if (o_ema_level !== lv.ema) begin
                    note_mismatch("ema_level", 64'(lv.ema), 64'(o_ema_level));
                end
                if (o_total_samples !== lv.total) begin
                    note_mismatch("total_samples", lv.total, o_total_samples);
                end
            end
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_weight_settings();
        test_extremes();
        test_full_block();
        test_backpressure();
        test_random();
        if (levels_due.size() != 0) begin
            note_mismatch("results still due", 64'(levels_due.size()), '0);
        end
        if (errors == 0) begin
            $display("audio_block_level_meter_top test passed");
        end else begin
            $display("audio_block_level_meter_top test failed");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT);
        $display("audio_block_level_meter_top test failed");
        $finish;
    end

endmodule
